// ===== src/rgbg3_pkg.sv =====
// Shared types, constants and helpers of the RGB 3x3 Gaussian filter.
`timescale 1ns / 1ps

package rgbg3_pkg;

    // frame size limits used as parameter defaults
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // pixel and arithmetic widths
    localparam int PIX_W    = 8;
    localparam int NUM_CH   = 3;
    localparam int RGB_W    = PIX_W * NUM_CH;
    localparam int WEIGHT_W = 16;
    localparam int FRAC_W   = 16;
    localparam int SUM4_W   = PIX_W + 2;               // sum of four samples
    localparam int PROD_W   = WEIGHT_W + SUM4_W;       // weight times four-sample sum
    localparam int CPROD_W  = WEIGHT_W + PIX_W;        // weight times center sample
    localparam int ACC_W    = WEIGHT_W + PIX_W + 4;    // up to nine weighted samples
    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

    // register file
    localparam int CFG_SIZE_W = 11;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT_CENTER = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT_EDGE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT_CORNER = 3'd4;

    localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_WIDTH   = 11'd512;
    localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_HEIGHT  = 11'd512;
    localparam logic [WEIGHT_W-1:0]   RST_WEIGHT_CENTER = 16'd7292;
    localparam logic [WEIGHT_W-1:0]   RST_WEIGHT_EDGE   = 16'd7285;
    localparam logic [WEIGHT_W-1:0]   RST_WEIGHT_CORNER = 16'd7276;

    // [0] red, [1] green, [2] blue
    typedef logic [NUM_CH-1:0][PIX_W-1:0] rgb_t;

    // where a scan item sits relative to the frame
    typedef struct packed {
        logic col_in;      // column inside the frame (not the padding column)
        logic row_in;      // row inside the frame (not the padding row)
        logic row_ge1;     // one row above exists
        logic row_ge2;     // two rows above exist
        logic col_zero;    // first column, window starts empty
        logic emit;        // item produces a filtered pixel
        logic row_end;
        logic frame_end;
    } pos_flags_t;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic int unsigned clamp_size(input logic [CFG_SIZE_W-1:0] v,
                                               input int unsigned max_size);
        int unsigned val;
        val = 32'(v);
        if (val == 0) begin
            return 1;
        end
        if (val > max_size) begin
            return max_size;
        end
        return val;
    endfunction

endpackage

// ===== src/rgbg3_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module rgbg3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rgb_gaussian_3x3_filter_core.sv =====
// Top level of the RGB 3x3 Gaussian filter: scan control, line stores, window and MAC pipeline.
`timescale 1ns / 1ps

// RGB 3x3 Gaussian blur over a raster pixel stream. The sender delivers
// (height+1) x (width+1) words in raster order: the extra last column and
// last row are padding, their samples are ignored and count as zero, as does
// everything outside the frame. Each word at scan position (r, c) with
// r >= 1 and c >= 1 yields the filtered pixel (r-1, c-1); other words yield
// nothing. Per channel the result is
//   center*P + edge*(sum of the edge neighbors) + corner*(sum of the diagonals),
// weights unsigned Q0.16, rounded once (add 2^15, drop 16 bits) and saturated
// to 255. m_tlast marks the last pixel of a row, m_tuser the last pixel of the
// frame. After the last padding word the scan wraps to 0, 0, so frames follow
// back to back without reset. Throughput is one word per clock while m_tready
// holds; a word passes the input register, the sum stage, the multiply stage
// and the round/saturate into the output register, which drives m_tvalid.
// Each pipeline stage stalls only when its successor is full, so words keep
// flowing into empty stages while a result waits at the output. The two line
// stores are RAMs of MAX_WIDTH x 24 bits, read once per word and written once
// per word that lies inside the frame columns;
// a high-water mark of written columns makes never-written entries read as
// zero, so no clearing pass runs after reset. Sizes of 0 act as 1, sizes above
// MAX_WIDTH / MAX_HEIGHT act as the maximum. Registers (APB, byte address
// 4*i): 0 image_width, 1 image_height, 2 weight_center, 3 weight_edge,
// 4 weight_corner; write them only while the stream is idle.

module rgb_gaussian_3x3_filter_core #(
    parameter int MAX_WIDTH  = rgbg3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgbg3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rgbg3_pkg::RGB_W-1:0]     s_tdata,   // red_in, green_in, blue_in

    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rgbg3_pkg::RGB_W-1:0]     m_tdata,   // red_out, green_out, blue_out
    output logic                            m_tlast,   // row_end
    output logic [0:0]                      m_tuser,   // frame_end

    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgbg3_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rgbg3_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rgbg3_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    import rgbg3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);       // line store address
    localparam int CW = $clog2(MAX_WIDTH + 1);   // column counter, holds the padding column
    localparam int RW = $clog2(MAX_HEIGHT + 1);  // row counter, holds the padding row

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [CFG_SIZE_W-1:0] cfg_width_reg;
    logic [CFG_SIZE_W-1:0] cfg_height_reg;
    logic [WEIGHT_W-1:0]   w_center_reg;
    logic [WEIGHT_W-1:0]   w_edge_reg;
    logic [WEIGHT_W-1:0]   w_corner_reg;
    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= RST_IMAGE_WIDTH;
            cfg_height_reg <= RST_IMAGE_HEIGHT;
            w_center_reg   <= RST_WEIGHT_CENTER;
            w_edge_reg     <= RST_WEIGHT_EDGE;
            w_corner_reg   <= RST_WEIGHT_CORNER;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:   cfg_width_reg  <= pwdata[CFG_SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_height_reg <= pwdata[CFG_SIZE_W-1:0];
                REG_WEIGHT_CENTER: w_center_reg   <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_EDGE:   w_edge_reg     <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_CORNER: w_corner_reg   <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(cfg_width_reg);
            REG_IMAGE_HEIGHT:  prdata = APB_DATA_W'(cfg_height_reg);
            REG_WEIGHT_CENTER: prdata = APB_DATA_W'(w_center_reg);
            REG_WEIGHT_EDGE:   prdata = APB_DATA_W'(w_edge_reg);
            REG_WEIGHT_CORNER: prdata = APB_DATA_W'(w_corner_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage moves when its successor has room
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic out_ready, s3_ready, s2_ready, s1_ready;
    logic accept, s1_go;

    assign out_ready = !out_valid_reg || m_tready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign accept    = s_tvalid && s1_ready;
    assign s1_go     = s1_valid_reg && s2_ready;

    // ------------------------------------------------------------------
    // Scan position
    // ------------------------------------------------------------------
    logic [CW-1:0] w_eff, col_reg, col_cur, col_next;
    logic [RW-1:0] h_eff, row_reg, row_cur, row_next;
    pos_flags_t    pos;

    assign w_eff   = CW'(clamp_size(cfg_width_reg, MAX_WIDTH));
    assign h_eff   = RW'(clamp_size(cfg_height_reg, MAX_HEIGHT));
    // a counter left beyond a shrunken size counts as the padding position
    assign col_cur = (col_reg > w_eff) ? w_eff : col_reg;
    assign row_cur = (row_reg > h_eff) ? h_eff : row_reg;

    always_comb begin
        pos.col_in    = col_cur < w_eff;
        pos.row_in    = row_cur < h_eff;
        pos.row_ge1   = row_cur != '0;
        pos.row_ge2   = row_cur >= RW'(2);
        pos.col_zero  = col_cur == '0;
        pos.emit      = (row_cur != '0) && (col_cur != '0);
        pos.row_end   = col_cur == w_eff;
        pos.frame_end = (col_cur == w_eff) && (row_cur == h_eff);
    end

    always_comb begin
        if (!pos.col_in) begin
            col_next = '0;
            row_next = pos.row_in ? row_cur + RW'(1) : '0;
        end else begin
            col_next = col_cur + CW'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register, line store read data arrives alongside
    // ------------------------------------------------------------------
    rgb_t       s1_pix_reg;
    logic [AW-1:0] s1_addr_reg;
    pos_flags_t s1_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= s_tdata;
            s1_addr_reg <= col_cur[AW-1:0];
            s1_pos_reg  <= pos;
        end
    end

    // line stores: upper holds the row two back, lower the row one back
    rgb_t upper_rd, lower_rd;
    rgb_t upper_wdata, lower_wdata;
    logic ls_wr;

    assign ls_wr = s1_go && s1_pos_reg.col_in;

    rgbg3_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_line_upper (
        .aclk    (aclk),
        .wr_en   (ls_wr),
        .wr_addr (s1_addr_reg),
        .wr_data (upper_wdata),
        .rd_en   (accept),
        .rd_addr (col_cur[AW-1:0]),
        .rd_data (upper_rd)
    );

    rgbg3_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_line_lower (
        .aclk    (aclk),
        .wr_en   (ls_wr),
        .wr_addr (s1_addr_reg),
        .wr_data (lower_wdata),
        .rd_en   (accept),
        .rd_addr (col_cur[AW-1:0]),
        .rd_data (lower_rd)
    );

    // columns are written contiguously from 0, so everything below the mark
    // has been written since reset; above it the stores read as zero
    logic [CW-1:0] hwm_reg, hwm_next;
    logic          ls_hit;

    assign ls_hit   = CW'(s1_addr_reg) < hwm_reg;
    assign hwm_next = (ls_wr && !ls_hit) ? CW'(s1_addr_reg) + CW'(1) : hwm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hwm_reg <= '0;
        end else begin
            hwm_reg <= hwm_next;
        end
    end

    // new window column and the two held ones
    rgb_t top, mid, bot;
    rgb_t win_reg [6];   // [0..2] column c-2 top/mid/bot, [3..5] column c-1
    rgb_t win_cur [6];

    always_comb begin
        top = (s1_pos_reg.col_in && s1_pos_reg.row_ge2 && ls_hit) ? upper_rd : '0;
        mid = (s1_pos_reg.col_in && s1_pos_reg.row_ge1 && ls_hit) ? lower_rd : '0;
        bot = (s1_pos_reg.col_in && s1_pos_reg.row_in) ? s1_pix_reg : '0;
        upper_wdata = ls_hit ? lower_rd : '0;
        lower_wdata = bot;
        for (int k = 0; k < 6; k++) begin
            win_cur[k] = s1_pos_reg.col_zero ? '0 : win_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            win_reg[0] <= win_cur[3];
            win_reg[1] <= win_cur[4];
            win_reg[2] <= win_cur[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= bot;
        end
    end

    // group the window by weight
    logic [NUM_CH-1:0][SUM4_W-1:0] corner_sum, edge_sum;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            corner_sum[ch] = SUM4_W'(win_cur[0][ch]) + SUM4_W'(win_cur[2][ch])
                           + SUM4_W'(top[ch]) + SUM4_W'(bot[ch]);
            edge_sum[ch]   = SUM4_W'(win_cur[1][ch]) + SUM4_W'(mid[ch])
                           + SUM4_W'(win_cur[3][ch]) + SUM4_W'(win_cur[5][ch]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: grouped sums
    // ------------------------------------------------------------------
    logic [NUM_CH-1:0][SUM4_W-1:0] s2_corner_reg, s2_edge_reg;
    rgb_t                          s2_center_reg;
    logic                          s2_row_end_reg, s2_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg && s1_pos_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            s2_corner_reg    <= corner_sum;
            s2_edge_reg      <= edge_sum;
            s2_center_reg    <= win_cur[4];
            s2_row_end_reg   <= s1_pos_reg.row_end;
            s2_frame_end_reg <= s1_pos_reg.frame_end;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: weighted products
    // ------------------------------------------------------------------
    logic [NUM_CH-1:0][PROD_W-1:0]  s3_corner_p_reg, s3_edge_p_reg;
    logic [NUM_CH-1:0][CPROD_W-1:0] s3_center_p_reg;
    logic                           s3_row_end_reg, s3_frame_end_reg;
    logic                           s2_go;

    assign s2_go = s2_valid_reg && s3_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_go) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                s3_corner_p_reg[ch] <= PROD_W'(w_corner_reg) * PROD_W'(s2_corner_reg[ch]);
                s3_edge_p_reg[ch]   <= PROD_W'(w_edge_reg) * PROD_W'(s2_edge_reg[ch]);
                s3_center_p_reg[ch] <= CPROD_W'(w_center_reg) * CPROD_W'(s2_center_reg[ch]);
            end
            s3_row_end_reg   <= s2_row_end_reg;
            s3_frame_end_reg <= s2_frame_end_reg;
        end
    end

    // ------------------------------------------------------------------
    // Round once, saturate, output register
    // ------------------------------------------------------------------
    logic [NUM_CH-1:0][ACC_W-1:0]        acc;
    logic [NUM_CH-1:0][ACC_W-FRAC_W-1:0] quot;
    rgb_t                                pix_out;
    rgb_t                                out_pix_reg;
    logic                                out_row_end_reg, out_frame_end_reg;
    logic                                s3_go;

    assign s3_go = s3_valid_reg && out_ready;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            acc[ch]  = ACC_W'(s3_corner_p_reg[ch]) + ACC_W'(s3_edge_p_reg[ch])
                     + ACC_W'(s3_center_p_reg[ch]) + ROUND_HALF;
            quot[ch] = acc[ch][ACC_W-1:FRAC_W];
            pix_out[ch] = (quot[ch] > (ACC_W-FRAC_W)'(PIX_MAX)) ? PIX_MAX
                                                                  : quot[ch][PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_go) begin
            out_pix_reg       <= pix_out;
            out_row_end_reg   <= s3_row_end_reg;
            out_frame_end_reg <= s3_frame_end_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_pix_reg;
    assign m_tlast    = out_row_end_reg;
    assign m_tuser[0] = out_frame_end_reg;

endmodule

// ===== tb/rgb_gaussian_3x3_filter_core_tb.sv =====
// Self-checking testbench for the RGB 3x3 Gaussian filter core.
`timescale 1ns / 1ps

module rgb_gaussian_3x3_filter_core_tb;
    import rgbg3_pkg::*;

    localparam int LINE_DEPTH   = DEF_MAX_WIDTH;
    localparam int ROW_LIMIT    = DEF_MAX_HEIGHT;
    localparam int DRAIN_CYCLES = 12;     // pipeline is 4 deep, keep some margin
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 90;

    typedef struct packed {
        rgb_t px;
        logic row_end;
        logic frame_end;
    } blur_pixel_t;

    // Tracks the filter state word by word and holds the pixels still owed.
    class blur_scoreboard;
        int unsigned   img_w_reg, img_h_reg;
        int unsigned   wt_center, wt_edge, wt_corner;
        rgb_t          line_upper [LINE_DEPTH];
        rgb_t          line_lower [LINE_DEPTH];
        rgb_t          win [6];   // [0..2] column c-2 top/mid/bot, [3..5] column c-1
        int unsigned   scan_col, scan_row;
        blur_pixel_t   pending [$];
        int            errors;

        function new();
            img_w_reg = RST_IMAGE_WIDTH;
            img_h_reg = RST_IMAGE_HEIGHT;
            wt_center = RST_WEIGHT_CENTER;
            wt_edge   = RST_WEIGHT_EDGE;
            wt_corner = RST_WEIGHT_CORNER;
            foreach (line_upper[i]) line_upper[i] = '0;
            foreach (line_lower[i]) line_lower[i] = '0;
            foreach (win[i]) win[i] = '0;
            scan_col = 0;
            scan_row = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_IMAGE_WIDTH:   img_w_reg = val[CFG_SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  img_h_reg = val[CFG_SIZE_W-1:0];
                REG_WEIGHT_CENTER: wt_center = val[WEIGHT_W-1:0];
                REG_WEIGHT_EDGE:   wt_edge   = val[WEIGHT_W-1:0];
                REG_WEIGHT_CORNER: wt_corner = val[WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // zero counts as one, oversize counts as the given limit
        function int unsigned fit_size(int unsigned v, int unsigned lim);
            if (v == 0) return 1;
            return (v > lim) ? lim : v;
        endfunction

        function logic [7:0] weigh(int unsigned corners, int unsigned edges,
                                   int unsigned center);
            longint unsigned acc;
            acc = longint'(wt_corner) * corners + longint'(wt_edge) * edges
                + longint'(wt_center) * center;
            acc = (acc + 64'd32768) >> 16;
            return (acc > 255) ? 8'hFF : acc[7:0];
        endfunction

        function void note_pixel(rgb_t px);
            int unsigned w, h, c, r;
            int unsigned corners, edges;
            rgb_t        top, mid, bot;
            blur_pixel_t res;
            w = fit_size(img_w_reg, LINE_DEPTH);
            h = fit_size(img_h_reg, ROW_LIMIT);
            // a counter left beyond a shrunk size sits on the padding position
            c = (scan_col > w) ? w : scan_col;
            r = (scan_row > h) ? h : scan_row;
            top = '0;
            mid = '0;
            bot = '0;
            if (c < w) begin
                if (r < h) bot = px;
                // rows above the frame are stale and read as zero
                if (r >= 2) top = line_upper[c];
                if (r >= 1) mid = line_lower[c];
                line_upper[c] = line_lower[c];
                line_lower[c] = bot;
            end
            if (c == 0) begin
                foreach (win[i]) win[i] = '0;
            end
            if (r >= 1 && c >= 1) begin
                for (int k = 0; k < NUM_CH; k++) begin
                    corners = win[0][k] + win[2][k] + top[k] + bot[k];
                    edges   = win[1][k] + win[3][k] + win[5][k] + mid[k];
                    res.px[k] = weigh(corners, edges, win[4][k]);
                end
                res.row_end   = (c == w);
                res.frame_end = (c == w) && (r == h);
                pending.push_back(res);
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = top;
            win[4] = mid;
            win[5] = bot;
            if (c >= w) begin
                scan_col = 0;
                scan_row = (r >= h) ? 0 : r + 1;
            end else begin
                scan_col = c + 1;
                scan_row = r;
            end
        endfunction

        function void check_pixel(rgb_t px, logic row_end, logic frame_end);
            string       chan_name [NUM_CH];
            blur_pixel_t exp_px;
            chan_name = '{"red_out", "green_out", "blue_out"};
            if (pending.size() == 0) begin
                $error("result word with no pixel expected: tdata %h", px);
                errors++;
                return;
            end
            exp_px = pending.pop_front();
            for (int k = 0; k < NUM_CH; k++) begin
                if (px[k] !== exp_px.px[k]) begin
                    $error("%s mismatch: expected %0d, got %0d",
                           chan_name[k], exp_px.px[k], px[k]);
                    errors++;
                end
            end
            if (row_end !== exp_px.row_end) begin
                $error("row_end mismatch: expected %0d, got %0d", exp_px.row_end, row_end);
                errors++;
            end
            if (frame_end !== exp_px.frame_end) begin
                $error("frame_end mismatch: expected %0d, got %0d",
                       exp_px.frame_end, frame_end);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [RGB_W-1:0]       s_tdata  = '0;   // red_in, green_in, blue_in
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [RGB_W-1:0]       m_tdata;         // red_out, green_out, blue_out
    logic                   m_tlast;         // row_end
    logic [0:0]             m_tuser;         // frame_end
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    blur_scoreboard sb = new();
    int             cfg_errors    = 0;
    int             words_sent    = 0;
    int             snd_idle_pct  = 0;
    int             rcv_idle_pct  = 0;
    bit             long_hold_req = 1'b0;

    rgb_gaussian_3x3_filter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random backpressure, plus one long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_pixel(m_tdata, m_tlast, m_tuser[0]);
        end
    end

    function automatic rgb_t rand_pixel();
        rgb_t px;
        for (int k = 0; k < NUM_CH; k++) begin
            case ($urandom_range(9))
                0:       px[k] = 8'h00;
                1:       px[k] = 8'hFF;
                default: px[k] = 8'($urandom_range(255));
            endcase
        end
        return px;
    endfunction

    // all driving tasks start and end at a falling edge
    task automatic send_word(input rgb_t px);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(px);
        words_sent++;
        @(negedge aclk);
    endtask

    // runs until the scan wraps to the top left corner
    task automatic send_frame();
        do send_word(rand_pixel()); while (sb.scan_col != 0 || sb.scan_row != 0);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // write, then read back
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        logic [31:0] rd, mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        mask = (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) ? 32'h7FF : 32'hFFFF;
        if (rd !== (val & mask)) begin
            $error("register %0d readback mismatch: expected %0d, got %0d",
                   idx, val & mask, rd);
            cfg_errors++;
        end
    endtask

    task automatic write_weights(input int unsigned wc, input int unsigned we,
                                 input int unsigned wk);
        write_reg(REG_WEIGHT_CENTER, wc);
        write_reg(REG_WEIGHT_EDGE, we);
        write_reg(REG_WEIGHT_CORNER, wk);
    endtask

    task automatic write_size(input int unsigned w, input int unsigned h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic random_config();
        int unsigned w, h;
        case ($urandom_range(9))
            0:       w = 0;
            1, 2:    w = $urandom_range(9, 24);
            default: w = $urandom_range(1, 8);
        endcase
        h = $urandom_range(0, 6);
        write_size(w, h);
        case ($urandom_range(3))
            0: write_weights(RST_WEIGHT_CENTER, RST_WEIGHT_EDGE, RST_WEIGHT_CORNER);
            1: write_weights($urandom_range(65535), $urandom_range(65535),
                             $urandom_range(65535));
            2: write_weights($urandom_range(16384), $urandom_range(12288),
                             $urandom_range(4096));
            default: write_weights($urandom_range(1) ? 16'hFFFF : 16'h0000,
                                   $urandom_range(1) ? 16'hFFFF : 16'h0000,
                                   $urandom_range(1) ? 16'hFFFF : 16'h0000);
        endcase
    endtask

    // mostly whole frames, some cut short with the size changed under the scan
    task automatic run_random_phase(input int goal);
        int start;
        start = words_sent;
        while (words_sent - start < goal) begin
            if ($urandom_range(99) < 40) begin
                wait_idle();
                random_config();
            end
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 12)) send_word(rand_pixel());
                wait_idle();
                write_size($urandom_range(0, 8), $urandom_range(0, 5));
            end
            send_frame();
        end
    endtask

    initial begin
        rgb_t corner_px [9];
        corner_px = '{24'hFFFFFF, 24'h000000, 24'h00FF00, 24'hFF0000, 24'h0000FF,
                      24'hFF00FF, 24'h00FFFF, 24'hFFFF00, 24'h808080};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        snd_idle_pct = 8;
        rcv_idle_pct = 75;

        // 2x2 frame, full-scale and mid-gray samples, Gaussian weights
        write_size(2, 2);
        write_weights(RST_WEIGHT_CENTER, RST_WEIGHT_EDGE, RST_WEIGHT_CORNER);
        foreach (corner_px[i]) send_word(corner_px[i]);

        // width of zero acts as one; full-scale weights saturate the sum
        wait_idle();
        write_size(0, 1);
        write_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (4) send_word(24'hFFFFFF);

        // zero weights give black whatever comes in
        wait_idle();
        write_weights(0, 0, 0);
        send_frame();

        // shrink both sizes mid-frame so the scan counters sit beyond them
        wait_idle();
        write_size(3, 3);
        write_weights(RST_WEIGHT_CENTER, RST_WEIGHT_EDGE, RST_WEIGHT_CORNER);
        repeat (10) send_word(rand_pixel());
        wait_idle();
        write_size(1, 1);
        send_frame();
        send_frame();

        run_random_phase(PHASE_WORDS);

        wait_idle();
        snd_idle_pct = 75;
        rcv_idle_pct = 8;
        run_random_phase(PHASE_WORDS);

        wait_idle();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;

        // long output stall while input keeps coming: block must fill and stall
        write_size(30, 4);
        write_weights(RST_WEIGHT_CENTER, RST_WEIGHT_EDGE, RST_WEIGHT_CORNER);
        long_hold_req = 1'b1;
        send_frame();

        // oversize sizes clamp to the maximum width and height; shrink partway into row 0
        wait_idle();
        write_size(2047, 2047);
        repeat (12) send_word(rand_pixel());
        wait_idle();
        write_size(4, 2);
        send_frame();

        run_random_phase(PHASE_WORDS);

        wait_idle();
        if (sb.errors == 0 && cfg_errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
